### hdl/bus_remote_terminal_responder_macros.svh
// Assertion macros shared by the responder's checker.
// Needs nothing else; a file takes it in with an include line.
`ifndef BUS_REMOTE_TERMINAL_RESPONDER_MACROS_SVH
`define BUS_REMOTE_TERMINAL_RESPONDER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BRTR_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("responder check failed");

// The condition must hold in the cycle after the trigger.
`define BRTR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("responder check failed");

`endif

### hdl/brtr_pkg.sv
// Types, sizes and codes of the remote terminal responder.
// Depends on nothing; the design files and the checker refer to it by scoped names.
`timescale 1ns / 1ps

package brtr_pkg;

   localparam int SLOT_COUNT        = 8;
   localparam int SUBADDR_COUNT     = 32;
   localparam int WORDS_PER_SUBADDR = 32;

   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SA_W        = $clog2(SUBADDR_COUNT);
   localparam int WORD_W      = $clog2(WORDS_PER_SUBADDR);
   localparam int STORE_AW    = SLOT_W + SA_W + WORD_W;
   localparam int STORE_DEPTH = SLOT_COUNT * SUBADDR_COUNT * WORDS_PER_SUBADDR;
   localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);
   localparam int FAULT_W     = 11;

   localparam logic [4:0] MAX_ADDR   = 5'd30;
   localparam logic [4:0] MODE_SA_LO = 5'd0;
   localparam logic [4:0] MODE_SA_HI = 5'd31;

   // Operation codes.
   localparam logic [2:0] OP_COMMAND = 3'd0;
   localparam logic [2:0] OP_EMULATE = 3'd1;
   localparam logic [2:0] OP_LOAD    = 3'd2;
   localparam logic [2:0] OP_FAULT   = 3'd3;
   localparam logic [2:0] OP_STOP    = 3'd4;
   localparam logic [2:0] OP_HALT    = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;

   // Result codes.
   localparam logic [1:0] CODE_OK       = 2'd0;
   localparam logic [1:0] CODE_BAD_ADDR = 2'd1;
   localparam logic [1:0] CODE_NO_SLOT  = 2'd2;
   localparam logic [1:0] CODE_INACTIVE = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [4:0]  rt_address;
      logic [4:0]  subaddress;
      logic [4:0]  word_count;
      logic        transmit;
      logic        bus_channel;
      logic [2:0]  slot_index;
      logic [4:0]  word_index;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] word;
      logic        channel;
      logic [1:0]  code;
      logic [3:0]  active_count;
      logic        last;
   } rsp_type;

   // Update of the slot table.
   typedef struct packed {
      logic               claim;
      logic               set_fault;
      logic               clear_all;
      logic [SLOT_W-1:0]  slot;
      logic [4:0]         address;
      logic [FAULT_W-1:0] fault;
   } slot_upd_type;

   // Address lookup and free slot search.
   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [FAULT_W-1:0] fault;
      logic               free_hit;
      logic [SLOT_W-1:0]  free_slot;
   } slot_find_type;

endpackage

### hdl/brtr_store.sv
// Transmit word store: one synchronous port, registered read data.
// Depends on brtr_pkg for its depth and address width.
`timescale 1ns / 1ps

module brtr_store (
   input  logic                          clock,
   input  logic                          write_en,
   input  logic                          read_en,
   input  logic [brtr_pkg::STORE_AW-1:0] addr,
   input  logic [15:0]                   write_data,
   output logic [15:0]                   read_data
);

   logic [15:0] mem [brtr_pkg::STORE_DEPTH];
   logic [15:0] read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= write_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

### hdl/brtr_slots.sv
// Slot table: active flags, emulated addresses and fault masks.
// Depends on brtr_pkg for the slot count and the update and lookup structs.
`timescale 1ns / 1ps

module brtr_slots (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [4:0]                         find_address,
   input  brtr_pkg::slot_upd_type             upd,
   output brtr_pkg::slot_find_type            find,
   output logic [brtr_pkg::SLOT_COUNT-1:0]    active,
   output logic [brtr_pkg::COUNT_W-1:0]       active_count
);

   logic [brtr_pkg::SLOT_COUNT-1:0] active_ff;
   logic [4:0]                      addr_ff  [brtr_pkg::SLOT_COUNT];
   logic [brtr_pkg::FAULT_W-1:0]    fault_ff [brtr_pkg::SLOT_COUNT];

   // Lookup and free search; scanning downward leaves the lowest slot.
   always_comb begin
      find = '0;
      for (int i = brtr_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (active_ff[i] && addr_ff[i] == find_address) begin
            find.hit  = 1'b1;
            find.slot = brtr_pkg::SLOT_W'(i);
         end
         if (!active_ff[i]) begin
            find.free_hit  = 1'b1;
            find.free_slot = brtr_pkg::SLOT_W'(i);
         end
      end
      find.fault = fault_ff[find.slot];
   end

   // Count of active slots.
   always_comb begin
      active_count = '0;
      for (int i = 0; i < brtr_pkg::SLOT_COUNT; i++) begin
         active_count = active_count + brtr_pkg::COUNT_W'(active_ff[i]);
      end
   end

   assign active = active_ff;

   // Active flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (upd.clear_all) begin
         active_ff <= '0;
      end else if (upd.claim) begin
         active_ff[upd.slot] <= 1'b1;
      end
   end

   // Addresses and fault masks.
   always_ff @(posedge clock) begin
      if (upd.claim) begin
         addr_ff[upd.slot]  <= upd.address;
         fault_ff[upd.slot] <= '0;
      end else if (upd.set_fault) begin
         fault_ff[upd.slot] <= upd.fault;
      end
   end

endmodule

### hdl/bus_remote_terminal_responder.sv
// Top level of the remote terminal responder.
// Depends on brtr_pkg, brtr_slots and brtr_store.
`timescale 1ns / 1ps

// After reset the block clears its transmit store, one word a cycle, over
// all SLOT_COUNT x 1024 words (8192 at the default size) and takes no beat
// until that pass ends. A set-up op answers with one acknowledgement. A
// command is decoded in the cycle it is taken, which also registers the status
// word, unless the block is halted or no slot emulates the address, when no
// result is sent; for a transmit the data words (32 at most) are then read out of
// the store's single port, each once the result side is free. One item is handled at a time.
module bus_remote_terminal_responder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brtr_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brtr_pkg::rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [brtr_pkg::STORE_AW-1:0]    clear_addr_ff, clear_addr_in;
   logic                             halted_ff, halted_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   brtr_pkg::rsp_type                rsp_ff, rsp_in;
   logic [brtr_pkg::SLOT_W-1:0]      rd_slot_ff, rd_slot_in;
   logic [4:0]                       rd_sa_ff, rd_sa_in;
   logic [4:0]                       rd_idx_ff, rd_idx_in;
   logic [5:0]                       remain_ff, remain_in;
   logic                             chan_ff, chan_in;

   brtr_pkg::slot_upd_type           upd;
   brtr_pkg::slot_find_type          find;
   logic [brtr_pkg::SLOT_COUNT-1:0]  active;
   logic [brtr_pkg::COUNT_W-1:0]     active_count;

   logic                             mem_we, mem_re;
   logic [brtr_pkg::STORE_AW-1:0]    mem_addr;
   logic [15:0]                      mem_wdata, mem_rdata;

   logic                             out_free, accept, mode, slot_ok;
   logic [brtr_pkg::SLOT_W-1:0]      si_slot;
   logic [3:0]                       cnt;

   brtr_slots u_slots (
      .clock        (clock),
      .reset        (reset),
      .find_address (req_item.rt_address),
      .upd          (upd),
      .find         (find),
      .active       (active),
      .active_count (active_count)
   );

   brtr_store u_store (
      .clock      (clock),
      .write_en   (mem_we),
      .read_en    (mem_re),
      .addr       (mem_addr),
      .write_data (mem_wdata),
      .read_data  (mem_rdata)
   );

   // Handshake and decode helpers.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign mode      = (req_item.subaddress == brtr_pkg::MODE_SA_LO) ||
                      (req_item.subaddress == brtr_pkg::MODE_SA_HI);
   assign si_slot   = brtr_pkg::SLOT_W'(req_item.slot_index);
   assign slot_ok   = (32'(req_item.slot_index) < brtr_pkg::SLOT_COUNT) && active[si_slot];
   assign cnt       = 4'(active_count);

   // Sequencer: clearing pass, item decode and data word streaming.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      halted_in     = halted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_slot_in    = rd_slot_ff;
      rd_sa_in      = rd_sa_ff;
      rd_idx_in     = rd_idx_ff;
      remain_in     = remain_ff;
      chan_in       = chan_ff;
      upd           = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = clear_addr_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clear_addr_ff == brtr_pkg::STORE_AW'(brtr_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               // Acknowledgement by default; ops below adjust it.
               rsp_in = '{kind: brtr_pkg::KIND_ACK, word: '0, channel: 1'b0,
                          code: brtr_pkg::CODE_OK, active_count: cnt, last: 1'b1};
               case (req_item.op)
                  brtr_pkg::OP_COMMAND: begin
                     if (!halted_ff && find.hit) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = brtr_pkg::KIND_STATUS;
                        rsp_in.word  = {req_item.rt_address, find.fault};
                        rsp_in.channel = req_item.bus_channel;
                        rsp_in.last  = !req_item.transmit;
                        if (req_item.transmit) begin
                           rd_slot_in = find.slot;
                           rd_sa_in   = mode ? brtr_pkg::MODE_SA_LO : req_item.subaddress;
                           rd_idx_in  = '0;
                           chan_in    = req_item.bus_channel;
                           if (mode) begin
                              remain_in = 6'd1;
                           end else if (req_item.word_count == 5'd0) begin
                              remain_in = 6'd32;
                           end else begin
                              remain_in = {1'b0, req_item.word_count};
                           end
                           mem_re   = 1'b1;
                           mem_addr = {find.slot, rd_sa_in, 5'd0};
                           state_in = ST_SEND;
                        end
                     end
                  end
                  brtr_pkg::OP_EMULATE: begin
                     rsp_valid_in = 1'b1;
                     upd.address  = req_item.rt_address;
                     if (req_item.rt_address > brtr_pkg::MAX_ADDR) begin
                        rsp_in.code = brtr_pkg::CODE_BAD_ADDR;
                     end else if (find.hit) begin
                        upd.claim = 1'b1;
                        upd.slot  = find.slot;
                     end else if (find.free_hit) begin
                        upd.claim = 1'b1;
                        upd.slot  = find.free_slot;
                        rsp_in.active_count = cnt + 4'd1;
                     end else begin
                        rsp_in.code = brtr_pkg::CODE_NO_SLOT;
                     end
                  end
                  brtr_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (slot_ok) begin
                        mem_we    = 1'b1;
                        mem_addr  = {si_slot, req_item.subaddress, req_item.word_index};
                        mem_wdata = req_item.value;
                     end else begin
                        rsp_in.code = brtr_pkg::CODE_INACTIVE;
                     end
                  end
                  brtr_pkg::OP_FAULT: begin
                     rsp_valid_in = 1'b1;
                     if (slot_ok) begin
                        upd.set_fault = 1'b1;
                        upd.slot      = si_slot;
                        upd.fault     = req_item.value[brtr_pkg::FAULT_W-1:0];
                     end else begin
                        rsp_in.code = brtr_pkg::CODE_INACTIVE;
                     end
                  end
                  brtr_pkg::OP_STOP: begin
                     rsp_valid_in        = 1'b1;
                     upd.clear_all       = 1'b1;
                     rsp_in.active_count = 4'd0;
                  end
                  brtr_pkg::OP_HALT: begin
                     rsp_valid_in        = 1'b1;
                     halted_in           = 1'b1;
                     upd.clear_all       = 1'b1;
                     rsp_in.active_count = 4'd0;
                  end
                  default: begin
                     // Unused op codes are dropped without a result.
                  end
               endcase
            end
         end

         ST_SEND: begin
            // Hand on the word last read from the store, then fetch the next one.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: brtr_pkg::KIND_DATA, word: mem_rdata, channel: chan_ff,
                          code: brtr_pkg::CODE_OK, active_count: cnt,
                          last: (remain_ff == 6'd1)};
               if (remain_ff == 6'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 5'd1;
                  remain_in = remain_ff - 6'd1;
                  mem_re    = 1'b1;
                  mem_addr  = {rd_slot_ff, rd_sa_ff, rd_idx_in};
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      rd_slot_ff <= rd_slot_in;
      rd_sa_ff   <= rd_sa_in;
      rd_idx_ff  <= rd_idx_in;
      remain_ff  <= remain_in;
      chan_ff    <= chan_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hdl/brtr_checker.sv
// Port checker for the remote terminal responder, bound to the top level.
// Depends on brtr_pkg and the responder's assertion macros.
`timescale 1ns / 1ps
`include "bus_remote_terminal_responder_macros.svh"

module brtr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input brtr_pkg::rsp_type rsp_item
);

   logic ack_beat, reply_beat, ack_empty, count_ok;

   // Beat classes and the conditions checked on them.
   assign ack_beat   = rsp_valid && (rsp_item.kind == brtr_pkg::KIND_ACK);
   assign reply_beat = rsp_valid && (rsp_item.kind != brtr_pkg::KIND_ACK);
   assign ack_empty  = rsp_item.last && (rsp_item.word == 16'd0) && !rsp_item.channel;
   assign count_ok   = 32'(rsp_item.active_count) <= brtr_pkg::SLOT_COUNT;

   // A stalled result beat stays put.
   `BRTR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // Acknowledgements are single, empty beats.
   `BRTR_ASSERT_NOW(a_ack_form, ack_beat, ack_empty)

   // Command replies never carry an error code.
   `BRTR_ASSERT_NOW(a_reply_code, reply_beat, rsp_item.code == brtr_pkg::CODE_OK)

   // The active count never exceeds the slot table.
   `BRTR_ASSERT_NOW(a_count_range, rsp_valid, count_ok)

endmodule

bind bus_remote_terminal_responder brtr_checker u_brtr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
